// File: rtl/core/selective_repeat_receiver_unit_macros.svh
// Assertion macros for the selective-repeat receiver checker.
// Needs nothing else; included by the checker file.
`ifndef SELECTIVE_REPEAT_RECEIVER_UNIT_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication
`define SRR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("srr assertion failed");

// next-cycle implication
`define SRR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("srr assertion failed");

`endif

// File: rtl/core/srr_pkg.sv
// Shared constants and helpers for the selective-repeat receiver.
// No dependencies.
`timescale 1ns / 1ps

package srr_pkg;

	localparam logic KIND_ACK     = 1'b0;
	localparam logic KIND_DELIVER = 1'b1;

	function automatic int pad_bytes(input int bits);
		return ((bits + 7) >> 3) << 3;
	endfunction

endpackage

// File: rtl/core/srr_front.sv
// Front end: accepts packets, drops bad-checksum ones, queues good ones.
// Two-entry queue toward srr_back. Depends on srr_pkg.
`timescale 1ns / 1ps

module srr_front
	import srr_pkg::*;
#(
	parameter int SEQ_BITS     = 3,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_ok,
	input  logic [SEQ_BITS-1:0]     in_seq,
	input  logic [PAYLOAD_BITS-1:0] in_payload,
	output logic                    q_valid,
	input  logic                    q_pop,
	output logic [SEQ_BITS-1:0]     q_seq,
	output logic [PAYLOAD_BITS-1:0] q_payload
);

	logic [SEQ_BITS-1:0]     seq_q     [2];
	logic [PAYLOAD_BITS-1:0] payload_q [2];
	logic                    wr_ptr_q;
	logic                    rd_ptr_q;
	logic [1:0]              count_q;
	logic                    push;
	logic                    pop;

	assign in_ready  = (count_q != 2'd2);
	assign push      = in_valid && in_ready && in_ok;
	assign q_valid   = (count_q != 2'd0);
	assign pop       = q_pop && q_valid;
	assign q_seq     = seq_q[rd_ptr_q];
	assign q_payload = payload_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			seq_q[wr_ptr_q]     <= in_seq;
			payload_q[wr_ptr_q] <= in_payload;
		end
	end

endmodule

// File: rtl/core/srr_back.sv
// Back end: window check, slot store, acknowledge and in-order delivery.
// Pops srr_front's queue, drives the result register. Depends on srr_pkg.
`timescale 1ns / 1ps

module srr_back
	import srr_pkg::*;
#(
	parameter int WINDOW_SIZE  = 4,
	parameter int SEQ_BITS     = 3,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	output logic                    q_pop,
	input  logic [SEQ_BITS-1:0]     q_seq,
	input  logic [PAYLOAD_BITS-1:0] q_payload,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    out_kind,
	output logic [SEQ_BITS-1:0]     out_ack,
	output logic [PAYLOAD_BITS-1:0] out_data,
	output logic                    out_last
);

	localparam int SLOT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int CMP_W  = (SEQ_BITS > 5) ? SEQ_BITS + 1 : 6;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DELIV = 1'b1;

	logic [PAYLOAD_BITS-1:0] slot_payload_q [WINDOW_SIZE];
	logic [WINDOW_SIZE-1:0]  slot_valid_q;
	logic [SLOT_W-1:0]       head_q;
	logic [SEQ_BITS-1:0]     base_q;
	logic                    state_q;

	logic                    out_valid_q;
	logic                    out_kind_q;
	logic [SEQ_BITS-1:0]     out_ack_q;
	logic [PAYLOAD_BITS-1:0] out_data_q;
	logic                    out_last_q;

	logic                    out_free;
	logic [SEQ_BITS-1:0]     offset;
	logic                    in_win;
	logic [SLOT_W:0]         pos_sum;
	logic [SLOT_W-1:0]       pos;
	logic [SLOT_W:0]         head_inc;
	logic [SLOT_W-1:0]       head_nxt;
	logic                    next_valid;
	logic                    take;
	logic                    deliver;

	assign out_free = !out_valid_q || out_ready;
	assign offset   = q_seq - base_q;
	assign in_win   = CMP_W'(offset) < CMP_W'(WINDOW_SIZE);
	assign pos_sum  = {1'b0, head_q} + (SLOT_W + 1)'(offset);
	assign pos      = (pos_sum >= (SLOT_W + 1)'(WINDOW_SIZE)) ?
		SLOT_W'(pos_sum - (SLOT_W + 1)'(WINDOW_SIZE)) : SLOT_W'(pos_sum);
	assign head_inc = {1'b0, head_q} + (SLOT_W + 1)'(1);
	assign head_nxt = (head_inc == (SLOT_W + 1)'(WINDOW_SIZE)) ?
		SLOT_W'(0) : SLOT_W'(head_inc);
	assign next_valid = slot_valid_q[head_nxt] && (head_nxt != head_q);

	assign take    = (state_q == ST_IDLE) && q_valid && out_free;
	assign deliver = (state_q == ST_DELIV) && out_free;
	assign q_pop   = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_valid_q <= '0;
			head_q       <= '0;
			base_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_free) out_valid_q <= take || deliver;
			case (state_q)
				ST_IDLE: begin
					if (take && in_win) begin
						slot_valid_q[pos] <= 1'b1;
						if (offset == '0) state_q <= ST_DELIV;
					end
				end
				ST_DELIV: begin
					if (deliver) begin
						slot_valid_q[head_q] <= 1'b0;
						head_q <= head_nxt;
						base_q <= base_q + SEQ_BITS'(1);
						if (!next_valid) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (in_win) slot_payload_q[pos] <= q_payload;
			out_kind_q <= KIND_ACK;
			out_ack_q  <= q_seq;
			out_data_q <= '0;
			out_last_q <= !(in_win && (offset == '0));
		end else if (deliver) begin
			out_kind_q <= KIND_DELIVER;
			out_ack_q  <= '0;
			out_data_q <= slot_payload_q[head_q];
			out_last_q <= !next_valid;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_ack   = out_ack_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

// File: rtl/core/selective_repeat_receiver_unit.sv
// Selective-repeat ARQ receiver, top level.
// Instantiates srr_front and srr_back; depends on srr_pkg.
//
// Input stream (s_*): one packet per transfer. s_tdata holds seq_num then
// payload_word; s_tuser is checksum_ok. Bad-checksum packets are taken and
// dropped without a result.
// Output stream (m_*): results. m_tdata holds ack_num then data_word;
// m_tuser is kind (0 ack, 1 delivery); m_tlast marks a packet's final result.
// A good packet yields one ack, and a base packet then one delivery per
// buffered in-order payload, up to WINDOW_SIZE of them.
// The back end handles a good packet as its ack and then its deliveries, and
// takes no new packet until they are done; the delivery loop emits one result per
// cycle from the slot store while m_tready allows. The first result passes through
// the queue and then the result register.
// A two-entry queue sits between intake and the window engine, so input keeps
// flowing while m_tready is low until the queue fills; results are held.
// Reset: all slots empty, window base and head slot at zero.
`timescale 1ns / 1ps

module selective_repeat_receiver_unit
	import srr_pkg::*;
#(
	parameter int WINDOW_SIZE  = 4,
	parameter int SEQ_BITS     = 3,
	parameter int PAYLOAD_BITS = 32,
	localparam int IN_W        = pad_bytes(SEQ_BITS + PAYLOAD_BITS),
	localparam int OUT_W       = pad_bytes(SEQ_BITS + PAYLOAD_BITS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // seq_num, payload_word, zero pad
	input  logic             s_tuser,  // checksum_ok
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // ack_num, data_word, zero pad
	output logic             m_tuser,  // kind
	output logic             m_tlast
);

	logic                    q_valid;
	logic                    q_pop;
	logic [SEQ_BITS-1:0]     q_seq;
	logic [PAYLOAD_BITS-1:0] q_payload;
	logic [SEQ_BITS-1:0]     out_ack;
	logic [PAYLOAD_BITS-1:0] out_data;

	srr_front #(
		.SEQ_BITS    (SEQ_BITS),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_ok     (s_tuser),
		.in_seq    (s_tdata[SEQ_BITS-1:0]),
		.in_payload(s_tdata[SEQ_BITS+PAYLOAD_BITS-1:SEQ_BITS]),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_seq     (q_seq),
		.q_payload (q_payload)
	);

	srr_back #(
		.WINDOW_SIZE (WINDOW_SIZE),
		.SEQ_BITS    (SEQ_BITS),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_seq    (q_seq),
		.q_payload(q_payload),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_kind (m_tuser),
		.out_ack  (out_ack),
		.out_data (out_data),
		.out_last (m_tlast)
	);

	assign m_tdata = OUT_W'({out_data, out_ack});

endmodule

// File: rtl/core/srr_checker.sv
// Port-level checker for selective_repeat_receiver_unit, bound to the top.
// Depends on srr_pkg and selective_repeat_receiver_unit_macros.svh.
`timescale 1ns / 1ps
`include "selective_repeat_receiver_unit_macros.svh"

module srr_checker
	import srr_pkg::*;
#(
	parameter int SEQ_BITS     = 3,
	parameter int PAYLOAD_BITS = 32,
	localparam int OUT_W       = pad_bytes(SEQ_BITS + PAYLOAD_BITS)
) (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tuser,
	input logic             m_tlast
);

	`SRR_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	`SRR_ASSERT_IMP(a_deliver_no_ack, clk, arst_n, m_tvalid && (m_tuser == KIND_DELIVER),
		m_tdata[SEQ_BITS-1:0] == '0)

	`SRR_ASSERT_IMP(a_ack_no_data, clk, arst_n, m_tvalid && (m_tuser == KIND_ACK),
		m_tdata[SEQ_BITS+PAYLOAD_BITS-1:SEQ_BITS] == '0)

	`SRR_ASSERT_NXT(a_ack_then_deliver, clk, arst_n,
		m_tvalid && m_tready && (m_tuser == KIND_ACK) && !m_tlast,
		!m_tvalid || (m_tuser == KIND_DELIVER))

endmodule

bind selective_repeat_receiver_unit srr_checker #(
	.SEQ_BITS    (SEQ_BITS),
	.PAYLOAD_BITS(PAYLOAD_BITS)
) u_srr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

// File: bench/srr_window_checker.sv
// Result checker for the selective-repeat receiver: tracks the receive window from the
// packet transfers it sees and compares every result transfer in order.
// Depends on srr_pkg for the result kind codes and the bus widths.
`timescale 1ns / 1ps

module srr_window_checker
	import srr_pkg::*;
#(
	parameter int WINDOW_SIZE  = 4,
	parameter int SEQ_BITS     = 3,
	parameter int PAYLOAD_BITS = 32,
	localparam int IN_W        = pad_bytes(SEQ_BITS + PAYLOAD_BITS),
	localparam int OUT_W       = pad_bytes(SEQ_BITS + PAYLOAD_BITS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // seq_num, payload_word, zero pad
	input  logic             s_tuser,   // checksum_ok
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,   // ack_num, data_word, zero pad
	input  logic             m_tuser,   // kind
	input  logic             m_tlast,
	output int               fail_count,
	output int               pending_count
);

	typedef struct packed {
		logic                    kind;
		logic [SEQ_BITS-1:0]     ack_num;
		logic [PAYLOAD_BITS-1:0] data_word;
		logic                    last;
	} rx_result_t;

	rx_result_t              due_results[$];
	logic [PAYLOAD_BITS-1:0] slot_word[WINDOW_SIZE];
	logic [WINDOW_SIZE-1:0]  slot_full;
	int unsigned             head;
	logic [SEQ_BITS-1:0]     base_seq;
	int                      errors = 0;

	function automatic rx_result_t make_result(input logic kind,
			input logic [SEQ_BITS-1:0] ack, input logic [PAYLOAD_BITS-1:0] word);
		rx_result_t r;
		r.kind      = kind;
		r.ack_num   = ack;
		r.data_word = word;
		r.last      = 1'b0;
		return r;
	endfunction

	// window bookkeeping for one accepted packet; queues the ack and any in-order releases
	task automatic accept_packet(input logic [SEQ_BITS-1:0] seq, input logic ok,
			input logic [PAYLOAD_BITS-1:0] word);
		logic [SEQ_BITS-1:0] delta;
		int unsigned         pos;
		int                  i;
		if (!ok)
			return;
		delta = seq - base_seq;
		if (int'(delta) >= WINDOW_SIZE) begin
			due_results.push_back(make_result(KIND_ACK, seq, '0));
		end else begin
			pos            = (head + delta) % WINDOW_SIZE;
			slot_word[pos] = word;
			slot_full[pos] = 1'b1;
			due_results.push_back(make_result(KIND_ACK, seq, '0));
			if (delta == 0) begin
				for (i = 0; i < WINDOW_SIZE; i++) begin
					if (!slot_full[head])
						break;
					due_results.push_back(make_result(KIND_DELIVER, '0, slot_word[head]));
					slot_full[head] = 1'b0;
					head            = (head + 1) % WINDOW_SIZE;
					base_seq        = base_seq + 1'b1;
				end
			end
		end
		due_results[due_results.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rx_result_t got;
		rx_result_t want;
		if (!arst_n) begin
			due_results.delete();
			slot_full = '0;
			head      = 0;
			base_seq  = '0;
		end else begin
			if (s_tvalid && s_tready)
				accept_packet(s_tdata[SEQ_BITS-1:0], s_tuser,
					s_tdata[SEQ_BITS +: PAYLOAD_BITS]);
			if (m_tvalid && m_tready) begin
				got.kind      = m_tuser;
				got.ack_num   = m_tdata[SEQ_BITS-1:0];
				got.data_word = m_tdata[SEQ_BITS +: PAYLOAD_BITS];
				got.last      = m_tlast;
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, %s",
						$time, "actual:");
					$display("    kind=%0d ack=%0d data=%h last=%0d",
						got.kind, got.ack_num, got.data_word, got.last);
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch, expected kind=%0d ack=%0d data=%h last=%0d,",
							$time, want.kind, want.ack_num, want.data_word, want.last);
						$display("    actual kind=%0d ack=%0d data=%h last=%0d",
							got.kind, got.ack_num, got.data_word, got.last);
					end
				end
			end
		end
		fail_count    <= errors;
		pending_count <= due_results.size();
	end

endmodule

// File: bench/testbench.sv
// Top of the selective-repeat receiver bench: clock, reset, packet stimulus, result-side
// back-pressure and the verdict. Needs srr_pkg, the receiver RTL and srr_window_checker.
`timescale 1ns / 1ps

module testbench;
	import srr_pkg::*;

	localparam int WINDOW_SIZE  = 4;
	localparam int SEQ_BITS     = 3;
	localparam int PAYLOAD_BITS = 32;
	localparam int IN_W         = pad_bytes(SEQ_BITS + PAYLOAD_BITS);
	localparam int OUT_W        = pad_bytes(SEQ_BITS + PAYLOAD_BITS);
	localparam int ITEM_TARGET  = 420;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 16;
	localparam int CYCLE_LIMIT  = 300000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             s_tuser = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tuser;
	logic             m_tlast;

	int                  fail_count;
	int                  pending_count;
	int                  good_sent = 0;
	int                  cycle_count = 0;
	int                  rx_wait = 0;
	logic                idle_on = 1'b1;
	logic                rx_hold = 1'b0;
	logic [SEQ_BITS-1:0] tx_base = '0;
	int                  order[WINDOW_SIZE];

	selective_repeat_receiver_unit #(
		.WINDOW_SIZE (WINDOW_SIZE),
		.SEQ_BITS    (SEQ_BITS),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	srr_window_checker #(
		.WINDOW_SIZE (WINDOW_SIZE),
		.SEQ_BITS    (SEQ_BITS),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// result side: random wait per transfer while idle_on, plus the long hold-off
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			rx_wait = idle_on ? $urandom_range(0, 15) : 0;
		else if (rx_wait > 0)
			rx_wait--;
		m_tready <= (rx_wait == 0) && !rx_hold;
	end

	initial begin
		while (good_sent < ITEM_TARGET / 2)
			@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	function automatic logic [PAYLOAD_BITS-1:0] rand_word();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return PAYLOAD_BITS'($urandom);
		endcase
	endfunction

	task automatic send_packet(input logic [SEQ_BITS-1:0] seq, input logic ok,
			input logic [PAYLOAD_BITS-1:0] word);
		int gap;
		gap = idle_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'({word, seq});
		s_tuser  <= ok;
		do @(posedge clk); while (!s_tready);
		if (ok)
			good_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	task automatic make_order(input int n);
		int i;
		int j;
		int t;
		for (i = 0; i < n; i++)
			order[i] = i;
		for (i = n - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			t        = order[i];
			order[i] = order[j];
			order[j] = t;
		end
	endtask

	// in-window packets in random order; stray packets before the window moves, drops and
	// resends mixed in
	task automatic window_burst();
		int k;
		int j;
		int n_stray;
		k       = $urandom_range(1, WINDOW_SIZE);
		n_stray = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		make_order(k);
		repeat (n_stray)
			send_packet(tx_base + SEQ_BITS'($urandom_range(WINDOW_SIZE, 2**SEQ_BITS - 1)),
				1'b1, rand_word());
		for (j = 0; j < k; j++) begin
			if ($urandom_range(0, 5) == 0)
				send_packet(SEQ_BITS'($urandom), 1'b0, rand_word());
			send_packet(tx_base + SEQ_BITS'(order[j]), 1'b1, rand_word());
			if (j > 0 && $urandom_range(0, 5) == 0)
				send_packet(tx_base + SEQ_BITS'(order[$urandom_range(0, j)]), 1'b1, rand_word());
		end
		tx_base = tx_base + SEQ_BITS'(k);
	endtask

	// base packet lost: later slots buffered, then the whole window resent
	task automatic lost_base_burst();
		int j;
		make_order(WINDOW_SIZE - 1);
		for (j = 0; j < WINDOW_SIZE - 1; j++)
			if ($urandom_range(0, 1))
				send_packet(tx_base + SEQ_BITS'(order[j] + 1), 1'b1, rand_word());
		make_order(WINDOW_SIZE);
		for (j = 0; j < WINDOW_SIZE; j++)
			send_packet(tx_base + SEQ_BITS'(order[j]), 1'b1, rand_word());
		tx_base = tx_base + SEQ_BITS'(WINDOW_SIZE);
	endtask

	initial begin
		int seg_left;
		seg_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_packet(3'd0, 1'b0, '1);           // bad checksum at the base
		send_packet(3'd5, 1'b1, 32'h0000_0001); // outside the window
		send_packet(3'd4, 1'b1, 32'h8000_0000); // just past the window
		send_packet(3'd7, 1'b1, 32'hDEAD_BEEF);
		send_packet(3'd3, 1'b1, '1);           // top of the window
		send_packet(3'd2, 1'b1, 32'hA5A5_A5A5);
		send_packet(3'd1, 1'b1, '0);
		send_packet(3'd2, 1'b1, 32'h5A5A_5A5A); // duplicate overwrites
		send_packet(3'd0, 1'b1, 32'h1234_5678); // releases the full window
		send_packet(3'd0, 1'b1, 32'h0F0F_0F0F); // already delivered
		send_packet(3'd3, 1'b1, 32'hF0F0_F0F0);
		send_packet(3'd4, 1'b1, 32'h0000_FFFF);
		send_packet(3'd6, 1'b1, 32'hFFFF_0000);
		send_packet(3'd5, 1'b1, 32'h7FFF_FFFF);
		send_packet(3'd1, 1'b1, 32'h1111_1111); // window wraps past seq 7
		send_packet(3'd0, 1'b1, 32'h2222_2222);
		send_packet(3'd7, 1'b0, 32'h3333_3333);
		send_packet(3'd7, 1'b1, 32'h4444_4444);
		send_packet(3'd2, 1'b0, '1);
		send_packet(3'd2, 1'b1, '0);
		tx_base = 3'd3;
		drain_results();

		while (good_sent < ITEM_TARGET) begin
			if (seg_left == 0) begin
				if ($urandom_range(0, 4) == 0)
					drain_results();
				idle_on <= ($urandom_range(0, 3) != 0);
				seg_left = 12;
			end
			seg_left--;
			if ($urandom_range(0, 9) < 8)
				window_burst();
			else
				lost_base_burst();
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
